/* hdl/sorted_table_binary_search_defines.svh */
// ----------------------------------------------------------------------------
// sorted_table_binary_search_defines
// Assertion macros used by the sorted table search engine.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that holds in the same cycle
`define STBS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// property that holds in the next cycle
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define STBS_ASSERT(label, ante, cons, msg)
`define STBS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hdl/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Types and constants of the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int CFG_W = 11;
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int POS_W = 10;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [VAL_W-1:0] search_key;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out;

    // command from the handshake side to the search engine
    typedef struct packed {
        logic                    do_write;
        logic                    do_search;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [VAL_W-1:0] search_key;
        logic [CFG_W-1:0]        entries_in_use;
    } t_cmd;

    // engine status back to the handshake side
    typedef struct packed {
        logic             idle;
        logic             done;
        logic             found;
        logic [POS_W-1:0] position;
    } t_stat;

endpackage

/* hdl/stbs_engine.sv */
// ----------------------------------------------------------------------------
// stbs_engine
// Table memory and bisection sequencer: one memory read and one compare
// per probe.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_defines.svh"

module stbs_engine #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stbs_pkg::t_cmd i_cmd,
    input  logic           i_ack,
    output stbs_pkg::t_stat o_stat
);
    import stbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = AW + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic signed [VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    logic [1:0]              r_state, n_state;
    logic [LW-1:0]           r_low, n_low;
    logic [LW-1:0]           r_high, n_high;
    logic [AW-1:0]           r_mid, n_mid;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic                    r_found, n_found;
    logic [POS_W-1:0]        r_pos, n_pos;

    logic [LW-1:0]           w_count;
    logic [LW:0]             w_sum;
    logic [AW-1:0]           w_mid_addr;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;

    // register value saturates at the table depth
    always_comb begin
        if (32'(i_cmd.entries_in_use) > 32'(TABLE_DEPTH)) begin
            w_count = LW'(TABLE_DEPTH);
        end else begin
            w_count = LW'(i_cmd.entries_in_use);
        end
    end

    assign w_sum      = {1'b0, r_low} + {1'b0, r_high};
    assign w_mid_addr = w_sum[AW:1];

    // writes beyond the table are dropped
    assign w_wr_en   = i_cmd.do_write && (32'(i_cmd.entry_index) < 32'(TABLE_DEPTH));
    assign w_wr_addr = AW'(i_cmd.entry_index);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_cmd.entry_value;
        end
        if (r_state == S_PROBE) begin
            r_rd_data <= r_mem[w_mid_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        n_low   = r_low;
        n_high  = r_high;
        n_mid   = r_mid;
        n_key   = r_key;
        n_found = r_found;
        n_pos   = r_pos;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.do_search) begin
                    n_low   = '0;
                    n_high  = w_count;
                    n_key   = i_cmd.search_key;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_low < r_high) begin
                    n_mid   = w_mid_addr;
                    n_state = S_CMP;
                end else begin
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (r_key > r_rd_data) begin
                    n_low   = {1'b0, r_mid} + LW'(1);
                    n_state = S_PROBE;
                end else if (r_key < r_rd_data) begin
                    n_high  = {1'b0, r_mid};
                    n_state = S_PROBE;
                end else begin
                    n_found = 1'b1;
                    n_pos   = POS_W'(r_mid);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_low   <= '0;
            r_high  <= '0;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_high  <= n_high;
        end
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign o_stat.idle     = (r_state == S_IDLE);
    assign o_stat.done     = (r_state == S_DONE);
    assign o_stat.found    = r_found;
    assign o_stat.position = r_pos;

    `STBS_ASSERT(a_write_only_idle, i_cmd.do_write, r_state == S_IDLE, "table write while busy")
    `STBS_ASSERT(a_cmp_range_open, r_state == S_CMP, r_low < r_high, "compare on empty range")
    `STBS_ASSERT(a_high_in_table, r_state != S_IDLE, r_high <= LW'(TABLE_DEPTH), "range past table")
    `STBS_ASSERT_NEXT(a_cmp_next, r_state == S_CMP, r_state == S_PROBE || r_state == S_DONE, "bad step after compare")

endmodule

/* hdl/sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted table of signed entries with bisection lookup.
// ----------------------------------------------------------------------------
// A write item stores one entry and gives no result; a search item bisects
// [0, entries_in_use), with the count saturated at the table depth, and
// returns one result item with the found flag and the matching position
// (zero on a miss). Each probe is a synchronous table read followed by a
// compare; the table has a single read port, so probes run one at a time.
// A finished result waits in the output register while the next item is
// taken. The table has no reset: search only entries that were written.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  stbs_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output stbs_pkg::t_out             o_out_data,
    input  logic                       i_cfg_we,
    input  logic [stbs_pkg::CFG_W-1:0] i_cfg_data
);
    import stbs_pkg::*;

    logic [CFG_W-1:0] r_entries, n_entries;
    logic             r_out_valid, n_out_valid;
    t_out             r_out_data, n_out_data;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic             w_accept;
    logic             w_out_free;
    logic             w_ack;

    assign o_in_stall = !w_stat.idle;
    assign w_accept   = i_in_valid && w_stat.idle;

    assign w_cmd.do_write       = w_accept && (i_in_data.func == FUNC_WRITE);
    assign w_cmd.do_search      = w_accept && (i_in_data.func == FUNC_SEARCH);
    assign w_cmd.entry_index    = i_in_data.entry_index;
    assign w_cmd.entry_value    = i_in_data.entry_value;
    assign w_cmd.search_key     = i_in_data.search_key;
    assign w_cmd.entries_in_use = r_entries;

    stbs_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_ack  (w_ack),
        .o_stat (w_stat)
    );

    // result moves into the output register once it is empty or draining
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_ack      = w_stat.done && w_out_free;

    always_comb begin
        n_entries   = r_entries;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (i_cfg_we) begin
            n_entries = i_cfg_data;
        end
        if (w_ack) begin
            n_out_valid         = 1'b1;
            n_out_data.found    = w_stat.found;
            n_out_data.position = w_stat.position;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_entries   <= n_entries;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* tb/tb_sorted_table_binary_search.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search
// Self-checking testbench for the sorted table binary search block.
// ----------------------------------------------------------------------------
// Loads sorted tables through write items, sets the entry count while the
// block is idle and sends search items whose results are predicted by a
// bisection over a local copy of the table. Directed cases cover the empty
// table, field extremes, an unsorted table and a full table with a saturated
// entry count; random phases vary table size, keys and handshake idling, and
// one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] FULL_STRIDE = 32'sh0040_0000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out             o_out_data;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    // local copy of the block's state
    logic signed [VAL_W-1:0] table_model [TABLE_DEPTH];
    logic [CFG_W-1:0]        entries_in_use_model;
    t_out                    pending_lookups[$];

    // entries already loaded during the full table test
    bit full_written [TABLE_DEPTH];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int idle_cycles;
    int mismatch_count;

    sorted_table_binary_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic t_out bisect_table(input logic signed [VAL_W-1:0] key);
        int               lo;
        int               hi;
        int               mid;
        logic [IDX_W-1:0] mid_idx;
        t_out             res;
        res = '0;
        lo  = 0;
        hi  = (entries_in_use_model > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_in_use_model);
        while (lo < hi) begin
            mid     = (lo + hi) >> 1;
            mid_idx = mid[IDX_W-1:0];
            if (key > table_model[mid_idx]) begin
                lo = mid + 1;
            end else if (key < table_model[mid_idx]) begin
                hi = mid;
            end else begin
                res.found    = 1'b1;
                res.position = mid[POS_W-1:0];
                break;
            end
        end
        return res;
    endfunction

    function automatic t_in make_write(input logic [IDX_W-1:0] idx,
                                       input logic signed [VAL_W-1:0] val);
        t_in it;
        it.func        = FUNC_WRITE;
        it.entry_index = idx;
        it.entry_value = val;
        it.search_key  = $urandom;
        return it;
    endfunction

    function automatic t_in make_search(input logic signed [VAL_W-1:0] key);
        t_in it;
        it.func        = FUNC_SEARCH;
        it.entry_index = IDX_W'($urandom);
        it.entry_value = $urandom;
        it.search_key  = key;
        return it;
    endfunction

    // keys mostly hit the loaded entries or land right next to them
    function automatic logic signed [VAL_W-1:0] pick_key(input int n);
        int sel;
        logic signed [VAL_W-1:0] base;
        if (n == 0) begin
            return $urandom;
        end
        sel  = $urandom_range(0, 9);
        base = table_model[IDX_W'($urandom_range(0, n - 1))];
        if (sel < 5) begin
            return base;
        end else if (sel < 6) begin
            return base + 1;
        end else if (sel < 7) begin
            return base - 1;
        end
        return $urandom;
    endfunction

    // entry i of the full table: strictly ascending across the whole range
    function automatic logic signed [VAL_W-1:0] full_entry(input int i);
        return VAL_MIN + VAL_W'(i) * FULL_STRIDE;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("result with no search pending",
                                int'(o_out_data.position), 0);
            end else begin
                want = pending_lookups.pop_front();
                if (o_out_data.found !== want.found) begin
                    report_mismatch("found", int'(o_out_data.found), int'(want.found));
                end
                if (o_out_data.position !== want.position) begin
                    report_mismatch("position", int'(o_out_data.position),
                                    int'(want.position));
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left    = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input t_in it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (it.func == FUNC_WRITE) begin
            table_model[it.entry_index] = it.entry_value;
        end else begin
            pending_lookups.push_back(bisect_table(it.search_key));
        end
    endtask

    // stop offering, wait for every result, then let a trailing write finish
    task automatic wait_all_results;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_lookups.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_entries_in_use(input logic [CFG_W-1:0] n);
        wait_all_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        entries_in_use_model = n;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // ascending values from a random start, clamped at the top (gives duplicates)
    task automatic load_sorted_table(input int n);
        longint level;
        longint step_max;
        int     i;
        level = ($urandom_range(0, 9) == 0) ? longint'(VAL_MIN) : longint'(int'($urandom));
        case ($urandom_range(0, 2))
            0: step_max = 3;
            1: step_max = 100000;
            default: step_max = 64'h1_0000_0000 / (n + 1);
        endcase
        for (i = 0; i < n; i++) begin
            send_item(make_write(i[IDX_W-1:0],
                                 (level > longint'(VAL_MAX)) ? VAL_MAX : level[VAL_W-1:0]));
            level += $urandom_range(0, int'(step_max));
        end
    endtask

    // loads only the full table entries that this key's bisection visits
    task automatic search_full_table(input logic signed [VAL_W-1:0] key);
        int                      lo;
        int                      hi;
        int                      mid;
        logic signed [VAL_W-1:0] val;
        lo = 0;
        hi = TABLE_DEPTH;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            val = full_entry(mid);
            if (!full_written[mid[IDX_W-1:0]]) begin
                send_item(make_write(mid[IDX_W-1:0], val));
                full_written[mid[IDX_W-1:0]] = 1'b1;
            end
            if (key > val) begin
                lo = mid + 1;
            end else if (key < val) begin
                hi = mid;
            end else begin
                break;
            end
        end
        send_item(make_search(key));
    endtask

    function automatic logic signed [VAL_W-1:0] pick_full_key();
        int idx;
        int sel;
        idx = $urandom_range(0, TABLE_DEPTH - 1);
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return full_entry(idx);
        end else if (sel < 7) begin
            return full_entry(idx) + 1;
        end else if (sel < 9) begin
            return full_entry(idx) - 1;
        end
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_table;
        set_idling(0, 0);
        write_entries_in_use(0);
        send_item(make_search(VAL_MIN));
        send_item(make_search(VAL_MAX));
    endtask

    task automatic test_directed_table;
        logic signed [VAL_W-1:0] vals [8];
        int i;
        vals = '{VAL_MIN, -70000, -1, 0, 1, 42, 900000, VAL_MAX};
        for (i = 0; i < 8; i++) begin
            send_item(make_write(i[IDX_W-1:0], vals[i[2:0]]));
        end
        send_item(make_write(10'd1023, $urandom));
        write_entries_in_use(8);
        send_item(make_search(VAL_MIN));
        send_item(make_search(VAL_MAX));
        send_item(make_search(0));
        send_item(make_search(42));
        send_item(make_search(2));
        send_item(make_search(VAL_MIN + 1));
        send_item(make_search(VAL_MAX - 1));
        // break the ordering and search across it
        send_item(make_write(10'd1, VAL_MAX));
        send_item(make_search(-70000));
        send_item(make_search(VAL_MAX));
    endtask

    task automatic test_full_table;
        int k;
        set_idling(0, 0);
        full_written = '{default: 1'b0};
        write_entries_in_use(CFG_W'(TABLE_DEPTH));
        search_full_table(VAL_MIN);
        search_full_table(VAL_MAX);
        search_full_table(full_entry(0));
        search_full_table(full_entry(TABLE_DEPTH - 1));
        for (k = 0; k < 8; k++) begin
            search_full_table(pick_full_key());
        end
        // count above the depth saturates
        write_entries_in_use('1);
        search_full_table(full_entry(TABLE_DEPTH - 1));
        for (k = 0; k < 8; k++) begin
            search_full_table(pick_full_key());
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input int budget);
        int sent;
        int n;
        int sel;
        int k;
        set_idling(send_pct, stall_pct);
        sent = 0;
        while (sent < budget) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                n = 0;
            end else if (sel < 8) begin
                n = $urandom_range(1, 24);
            end else begin
                n = $urandom_range(25, 100);
            end
            load_sorted_table(n);
            write_entries_in_use(n[CFG_W-1:0]);
            sent += n;
            for (k = $urandom_range(10, 30); k > 0; k--) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(make_write(IDX_W'($urandom), $urandom));
                end else begin
                    send_item(make_search(pick_key(n)));
                end
                sent++;
            end
        end
    endtask

    task automatic test_backpressure;
        int k;
        set_idling(0, 0);
        load_sorted_table(40);
        write_entries_in_use(40);
        @(posedge i_clk);
        hold_request = HOLD_CYCLES;
        for (k = 0; k < 24; k++) begin
            send_item(make_search(pick_key(40)));
        end
        // sender pauses until the block has emptied
        wait_all_results();
        set_idling(30, 30);
        for (k = 0; k < 20; k++) begin
            send_item(make_search(pick_key(40)));
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_in_data            = '0;
        i_out_stall          = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = '0;
        entries_in_use_model = '0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        hold_request         = 0;
        hold_left            = 0;
        idle_cycles          = 0;
        mismatch_count       = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_table();
        test_full_table();
        test_random_traffic(0, 0, 75);
        test_random_traffic(55, 0, 75);
        test_random_traffic(0, 55, 75);
        test_random_traffic(30, 30, 75);
        test_backpressure();

        wait_all_results();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
